### rtl/core/itoa_pkg.sv
package itoa_pkg;

	localparam int VALUE_BITS_DEF = 32;

	// Format codes carried in the cmd field
	localparam logic [1:0] FMT_UDEC = 2'd0;
	localparam logic [1:0] FMT_SDEC = 2'd1;
	localparam logic [1:0] FMT_HEX  = 2'd2;
	localparam logic [1:0] FMT_OCT  = 2'd3;

	typedef logic [7:0] char_t;

	localparam char_t CH_ZERO  = 8'h30;  // '0'
	localparam char_t CH_X     = 8'h58;  // 'X'
	localparam char_t CH_O     = 8'h6F;  // 'o'
	localparam char_t CH_MINUS = 8'h2D;  // '-'
	localparam char_t CH_SPACE = 8'h20;  // ' '
	localparam char_t CH_ALPHA = 8'h37;  // 'A' minus ten

	// Map one digit (0..15) to its upper-case ASCII character
	function automatic char_t digit_char(input logic [3:0] d);
		char_t c;
		if (d < 4'd10) begin
			c = CH_ZERO + char_t'(d);
		end else begin
			c = CH_ALPHA + char_t'(d);
		end
		return c;
	endfunction

endpackage

### rtl/core/itoa_if.sv
interface itoa_in_if #(
	parameter int VALUE_BITS = itoa_pkg::VALUE_BITS_DEF
);
	logic                  valid;
	logic                  ready;
	logic [1:0]            cmd;
	logic [VALUE_BITS-1:0] value;

	modport source (output valid, output cmd, output value, input ready);
	modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface itoa_out_if;
	logic            valid;
	logic            ready;
	itoa_pkg::char_t char_out;
	logic            last;

	modport source (output valid, output char_out, output last, input ready);
	modport sink   (input valid, input char_out, input last, output ready);
endinterface

### rtl/core/integer_to_ascii_radix_top.sv
// Decimal runs the shared add-3/shift step once per value bit before its first character;
//   hex and octal go straight to their prefix, and output stalls delay every format.
// One number is converted at a time; the next is taken the cycle after the trailing space
//   of the last is loaded into the output register.
// Reset: arst_n clears the sequencer and the output valid; the block comes up idle.
module integer_to_ascii_radix_top #(
	parameter int VALUE_BITS = itoa_pkg::VALUE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	itoa_in_if.sink     din,
	itoa_out_if.source  dout
);

	// Digit counts for the widest value in each radix
	localparam int NDEC    = (VALUE_BITS * 30103) / 100000 + 1;
	localparam int NHEX    = (VALUE_BITS + 3) / 4;
	localparam int NOCT    = (VALUE_BITS + 2) / 3;
	localparam int WORK_W  = 4 * NDEC;
	localparam int HEX_SH  = WORK_W - 4 * NHEX;
	localparam int OCT_SH  = WORK_W - 3 * NOCT;
	localparam int CNT_W   = $clog2(NOCT + 1);
	localparam int STEP_W  = $clog2(VALUE_BITS + 1);

	// Sequencer states
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_CONV = 3'd1;
	localparam logic [2:0] S_PRE  = 3'd2;
	localparam logic [2:0] S_DIG  = 3'd3;
	localparam logic [2:0] S_SPC  = 3'd4;

	logic [2:0]            state_q, state_nx;
	logic [1:0]            cmd_q;
	logic                  neg_q;
	logic                  pre_q;        // second prefix character of "0X"
	logic                  started_q;    // first nonzero digit already sent
	logic [CNT_W-1:0]      cnt_q;        // digits still in the work register
	logic [STEP_W-1:0]     step_q;       // conversion steps left
	logic [WORK_W-1:0]     work_q;       // BCD or radix digits, most significant at the top
	logic [VALUE_BITS-1:0] bin_q;        // binary left to shift into the BCD digits

	logic                  out_valid_q;
	itoa_pkg::char_t       char_q;
	logic                  last_q;

	logic                  accept;
	logic                  can_emit;
	logic                  emit;
	itoa_pkg::char_t       emit_char;
	logic                  emit_last;
	logic [VALUE_BITS-1:0] v_in;
	logic                  neg_in;
	logic [VALUE_BITS-1:0] mag_in;
	logic [3:0]            dig;
	logic                  skip;
	logic [WORK_W-1:0]     bcd_nx;
	logic [VALUE_BITS-1:0] bin_nx;

	// Shared conversion unit: one binary bit enters the BCD digits per cycle
	itoa_dabble #(
		.VALUE_BITS(VALUE_BITS),
		.NDEC      (NDEC)
	) u_dabble (
		.bcd   (work_q),
		.bin   (bin_q),
		.bcd_nx(bcd_nx),
		.bin_nx(bin_nx)
	);

	assign din.ready = (state_q == S_IDLE);
	assign accept    = din.valid && din.ready;

	// Signed decimal prints the magnitude of a negative value as unsigned
	assign v_in   = din.value[VALUE_BITS-1:0];
	assign neg_in = (din.cmd == itoa_pkg::FMT_SDEC) && v_in[VALUE_BITS-1];
	assign mag_in = neg_in ? VALUE_BITS'(~v_in + VALUE_BITS'(1)) : v_in;

	// Top digit of the work register; octal digits are three bits wide
	assign dig = (cmd_q == itoa_pkg::FMT_OCT) ? {1'b0, work_q[WORK_W-1 -: 3]}
	                                          : work_q[WORK_W-1 -: 4];
	// Drop leading zeros, but always keep the final digit
	assign skip = (dig == 4'd0) && !started_q && (cnt_q > CNT_W'(1));

	// A character may be produced when the output register is free or draining
	assign can_emit = !out_valid_q || dout.ready;

	always_comb begin
		state_nx  = state_q;
		emit      = 1'b0;
		emit_char = itoa_pkg::CH_SPACE;
		emit_last = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (din.cmd == itoa_pkg::FMT_UDEC || din.cmd == itoa_pkg::FMT_SDEC) begin
						state_nx = S_CONV;
					end else begin
						state_nx = S_PRE;
					end
				end
			end
			S_CONV: begin
				if (step_q == STEP_W'(1)) begin
					state_nx = neg_q ? S_PRE : S_DIG;
				end
			end
			S_PRE: begin
				case (cmd_q)
					itoa_pkg::FMT_HEX: emit_char = pre_q ? itoa_pkg::CH_X : itoa_pkg::CH_ZERO;
					itoa_pkg::FMT_OCT: emit_char = itoa_pkg::CH_O;
					default:           emit_char = itoa_pkg::CH_MINUS;
				endcase
				emit = can_emit;
				if (can_emit && (cmd_q != itoa_pkg::FMT_HEX || pre_q)) begin
					state_nx = S_DIG;
				end
			end
			S_DIG: begin
				emit_char = itoa_pkg::digit_char(dig);
				emit      = can_emit && !skip;
				if ((skip || can_emit) && cnt_q == CNT_W'(1)) begin
					state_nx = S_SPC;
				end
			end
			S_SPC: begin
				emit_last = 1'b1;
				emit      = can_emit;
				if (can_emit) begin
					state_nx = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (dout.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath: load on accept, then step, shift or advance as the sequencer moves
	always_ff @(posedge clk) begin
		if (emit) begin
			char_q <= emit_char;
			last_q <= emit_last;
		end
		if (accept) begin
			cmd_q     <= din.cmd;
			neg_q     <= neg_in;
			pre_q     <= 1'b0;
			started_q <= 1'b0;
			bin_q     <= mag_in;
			step_q    <= STEP_W'(VALUE_BITS);
			case (din.cmd)
				itoa_pkg::FMT_HEX: begin
					work_q <= WORK_W'(mag_in) << HEX_SH;
					cnt_q  <= CNT_W'(NHEX);
				end
				itoa_pkg::FMT_OCT: begin
					work_q <= WORK_W'(mag_in) << OCT_SH;
					cnt_q  <= CNT_W'(NOCT);
				end
				default: begin
					work_q <= '0;
					cnt_q  <= CNT_W'(NDEC);
				end
			endcase
		end else if (state_q == S_CONV) begin
			work_q <= bcd_nx;
			bin_q  <= bin_nx;
			step_q <= step_q - STEP_W'(1);
		end else if (state_q == S_PRE && emit) begin
			pre_q <= 1'b1;
		end else if (state_q == S_DIG && (skip || can_emit)) begin
			if (!skip) begin
				started_q <= 1'b1;
			end
			if (cmd_q == itoa_pkg::FMT_OCT) begin
				work_q <= work_q << 3;
			end else begin
				work_q <= work_q << 4;
			end
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	assign dout.valid    = out_valid_q;
	assign dout.char_out = char_q;
	assign dout.last     = last_q;

	// Conversion never runs out of steps while still in progress
	a_conv_steps: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CONV |-> step_q != '0)
		else $error("conversion step count reached zero inside conversion");

	// Digit emission always has at least one digit left
	a_dig_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIG |-> cnt_q != '0)
		else $error("digit count empty while emitting digits");

	// Only the trailing space is marked last
	a_last_space: assert property (@(posedge clk) disable iff (!arst_n)
		emit && state_q == S_SPC |=> dout.valid && dout.last &&
			dout.char_out == itoa_pkg::CH_SPACE)
		else $error("trailing space not presented as last character");

	// Every other character goes out without the last mark
	a_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		emit && state_q != S_SPC |=> dout.valid && !dout.last)
		else $error("non-final character marked last");

endmodule

### rtl/core/itoa_dabble.sv
// One shift-and-add-3 step of binary to BCD conversion.
module itoa_dabble #(
	parameter int VALUE_BITS = itoa_pkg::VALUE_BITS_DEF,
	parameter int NDEC       = 10
) (
	input  logic [4*NDEC-1:0]     bcd,
	input  logic [VALUE_BITS-1:0] bin,
	output logic [4*NDEC-1:0]     bcd_nx,
	output logic [VALUE_BITS-1:0] bin_nx
);

	logic [4*NDEC-1:0] adj;

	// Correct every BCD digit of five or more so the shift carries into the next digit
	always_comb begin
		for (int i = 0; i < NDEC; i++) begin
			if (bcd[4*i +: 4] >= 4'd5) begin
				adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
			end else begin
				adj[4*i +: 4] = bcd[4*i +: 4];
			end
		end
	end

	assign bcd_nx = {adj[4*NDEC-2:0], bin[VALUE_BITS-1]};
	assign bin_nx = {bin[VALUE_BITS-2:0], 1'b0};

endmodule
